/* rtl/rdgv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdgv_pkg
// Types, widths and helpers shared by the radial distortion grid vertex unit.
// ----------------------------------------------------------------------------
package rdgv_pkg;

  localparam int NCOEF   = 7;
  localparam int COEF_W  = 24;
  localparam int CRD_W   = 15;
  localparam int R2_W    = 30;
  localparam int ROOT_W  = 15;
  localparam int REM_W   = 18;
  localparam int ACC_W   = 30;
  localparam int XO_W    = 18;
  localparam int VIDX_W  = 11;
  localparam int IDX_W   = 6;
  localparam int CIDX_W  = 3;
  localparam int SQ_STG  = 5;
  localparam int SQ_STEP = 3;
  localparam int ONE_Q14 = 16384;
  localparam int X_MAX   = 131071;
  localparam int X_MIN   = -131072;

  typedef struct packed {
    logic signed [CRD_W-1:0] xu;
    logic signed [CRD_W-1:0] yu;
    logic [VIDX_W-1:0]       vidx;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    sq_t              nxt;
    rem_sh = {cur.rem[REM_W-3:0], pair};
    trial  = {1'b0, cur.root, 2'b01};
    if (rem_sh >= trial) begin
      nxt.rem  = rem_sh - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

/* rtl/radial_distortion_grid_vertex_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_distortion_grid_vertex_unit
// Places a grid vertex on the -1..0 grid, takes its radius and scales x by a
// configurable degree-six radial polynomial evaluated by Horner's rule.
//
//   Channel  Direction  Handshake            Payload
//   in_      request    in_valid / in_stall  in_col, in_row
//   out_     result     out_valid/out_stall  out_x_out, out_y_out,
//                                            out_vertex_index
//   cfg_     write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Fifteen register stages: coordinates, radius squared, five square root
// stages, six Horner stages, the final product and the output register.
// One request per cycle while the output is not stalled. Each stage holds when
// the one after it is full and held, so a stall fills bubbles first and nothing
// is lost or repeated.
// Reset clears all valid bits and loads the coefficient reset values.
// ----------------------------------------------------------------------------
module radial_distortion_grid_vertex_unit #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rdgv_pkg::IDX_W-1:0]          in_col,
  input  logic [rdgv_pkg::IDX_W-1:0]          in_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rdgv_pkg::XO_W-1:0]    out_x_out,
  output logic signed [rdgv_pkg::CRD_W-1:0]   out_y_out,
  output logic [rdgv_pkg::VIDX_W-1:0]         out_vertex_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdgv_pkg::CIDX_W-1:0]         cfg_index,
  input  logic signed [rdgv_pkg::COEF_W-1:0]  cfg_data
);

  localparam int NS     = 15;
  localparam int S_R2   = 1;
  localparam int S_SQ   = 2;
  localparam int S_HOR  = S_SQ + rdgv_pkg::SQ_STG;
  localparam int NHOR   = rdgv_pkg::NCOEF - 1;
  localparam int S_PROD = S_HOR + NHOR;
  localparam int NTAB   = 2 ** rdgv_pkg::IDX_W;
  localparam logic [rdgv_pkg::VIDX_W-1:0] ROW_STRIDE = rdgv_pkg::VIDX_W'(GRID_X + 1);

  logic signed [rdgv_pkg::COEF_W-1:0] coef_r [rdgv_pkg::NCOEF];
  logic [NS-1:0]                      v_r;
  logic [NS:0]                        en;

  rdgv_pkg::side_t                    sb_r [S_PROD+1];
  logic [rdgv_pkg::R2_W-1:0]          r2_r;
  logic [rdgv_pkg::ROOT_W-1:0]        root;
  logic signed [rdgv_pkg::ACC_W-1:0]  acc_r [NHOR];
  logic [rdgv_pkg::ROOT_W-1:0]        rad_r [NHOR];
  logic signed [44:0]                 p_r;
  logic signed [rdgv_pkg::XO_W-1:0]   x_out_r;
  logic signed [rdgv_pkg::CRD_W-1:0]  y_out_r;
  logic [rdgv_pkg::VIDX_W-1:0]        vidx_r;

  logic signed [rdgv_pkg::CRD_W-1:0]  xtab [NTAB];
  logic signed [rdgv_pkg::CRD_W-1:0]  ytab [NTAB];

  for (genvar i = 0; i < NTAB; i++) begin : g_tab
    localparam int QX = (i * rdgv_pkg::ONE_Q14 + GRID_X / 2) / GRID_X;
    localparam int QY = (i * rdgv_pkg::ONE_Q14 + GRID_Y / 2) / GRID_Y;
    assign xtab[i] = rdgv_pkg::CRD_W'(QX - rdgv_pkg::ONE_Q14);
    assign ytab[i] = rdgv_pkg::CRD_W'(QY - rdgv_pkg::ONE_Q14);
  end

  // Flow control.
  assign en[NS] = !out_stall;
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end
  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k < rdgv_pkg::NCOEF; k++) begin
        coef_r[k] <= '0;
      end
      coef_r[0] <= rdgv_pkg::COEF_W'(1 << 20);
    end else if (cfg_valid && cfg_ready && (int'(cfg_index) < rdgv_pkg::NCOEF)) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // Stage 0: clamp and grid coordinates.
  logic [rdgv_pkg::IDX_W-1:0] col_c;
  logic [rdgv_pkg::IDX_W-1:0] row_c;
  rdgv_pkg::side_t            sb_nxt;

  always_comb begin
    col_c = (int'(in_col) > GRID_X) ? rdgv_pkg::IDX_W'(GRID_X) : in_col;
    row_c = (int'(in_row) > GRID_Y) ? rdgv_pkg::IDX_W'(GRID_Y) : in_row;
    sb_nxt.xu   = xtab[col_c];
    sb_nxt.yu   = ytab[row_c];
    sb_nxt.vidx = rdgv_pkg::VIDX_W'(row_c) * ROW_STRIDE + rdgv_pkg::VIDX_W'(col_c);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sb_r[0] <= sb_nxt;
    end
    for (int i = 1; i <= S_PROD; i++) begin
      if (en[i]) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // Stage 1: radius squared.
  logic signed [29:0] xsq;
  logic signed [29:0] ysq;

  assign xsq = sb_r[0].xu * sb_r[0].xu;
  assign ysq = sb_r[0].yu * sb_r[0].yu;

  always_ff @(posedge clk) begin
    if (en[S_R2]) begin
      r2_r <= rdgv_pkg::R2_W'(xsq) + rdgv_pkg::R2_W'(ysq);
    end
  end

  rdgv_sqrt u_sqrt (
    .clk      (clk),
    .en       (en[S_SQ +: rdgv_pkg::SQ_STG]),
    .r2_in    (r2_r),
    .root_out (root)
  );

  // Horner stages.
  for (genvar j = 0; j < NHOR; j++) begin : g_hor
    logic signed [rdgv_pkg::ACC_W-1:0] acc_in;
    logic [rdgv_pkg::ROOT_W-1:0]       rad_in;
    logic signed [45:0]                prod;
    logic signed [45:0]                prod_rnd;
    logic signed [31:0]                acc_sum;

    if (j == 0) begin : g_first
      assign acc_in = rdgv_pkg::ACC_W'(coef_r[rdgv_pkg::NCOEF-1]);
      assign rad_in = root;
    end else begin : g_next
      assign acc_in = acc_r[j-1];
      assign rad_in = rad_r[j-1];
    end

    assign prod     = acc_in * $signed({1'b0, rad_in});
    assign prod_rnd = prod + 46'sd8192;
    assign acc_sum  = $signed(prod_rnd[45:14]) + 32'(coef_r[NHOR-1-j]);

    always_ff @(posedge clk) begin
      if (en[S_HOR+j]) begin
        acc_r[j] <= acc_sum[rdgv_pkg::ACC_W-1:0];
        rad_r[j] <= rad_in;
      end
    end
  end

  // Final product, then round and saturate.
  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      p_r <= sb_r[S_PROD-1].xu * acc_r[NHOR-1];
    end
  end

  logic signed [44:0] p_rnd;
  logic signed [24:0] x_full;
  logic signed [rdgv_pkg::XO_W-1:0] x_sat;

  always_comb begin
    p_rnd  = p_r + 45'sd524288;
    x_full = p_rnd[44:20];
    if (x_full > 25'(rdgv_pkg::X_MAX)) begin
      x_sat = rdgv_pkg::XO_W'(rdgv_pkg::X_MAX);
    end else if (x_full < 25'(rdgv_pkg::X_MIN)) begin
      x_sat = rdgv_pkg::XO_W'(rdgv_pkg::X_MIN);
    end else begin
      x_sat = x_full[rdgv_pkg::XO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      x_out_r <= x_sat;
      y_out_r <= sb_r[S_PROD].yu;
      vidx_r  <= sb_r[S_PROD].vidx;
    end
  end

  assign out_x_out        = x_out_r;
  assign out_y_out        = y_out_r;
  assign out_vertex_index = vidx_r;

endmodule

/* rtl/rdgv_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdgv_sqrt
// Pipelined integer square root, three result bits per register stage.
// ----------------------------------------------------------------------------
module rdgv_sqrt (
  input  logic                             clk,
  input  logic [rdgv_pkg::SQ_STG-1:0]      en,
  input  logic [rdgv_pkg::R2_W-1:0]        r2_in,
  output logic [rdgv_pkg::ROOT_W-1:0]      root_out
);

  rdgv_pkg::sq_t                   st_r  [rdgv_pkg::SQ_STG];
  logic [rdgv_pkg::R2_W-1:0]       val_r [rdgv_pkg::SQ_STG];

  for (genvar s = 0; s < rdgv_pkg::SQ_STG; s++) begin : g_stg
    rdgv_pkg::sq_t             st_in;
    logic [rdgv_pkg::R2_W-1:0] val_in;
    rdgv_pkg::sq_t             st_nxt;

    if (s == 0) begin : g_first
      assign st_in  = '0;
      assign val_in = r2_in;
    end else begin : g_next
      assign st_in  = st_r[s-1];
      assign val_in = val_r[s-1];
    end

    always_comb begin
      st_nxt = st_in;
      for (int t = 0; t < rdgv_pkg::SQ_STEP; t++) begin
        st_nxt = rdgv_pkg::sqrt_step(st_nxt,
                   val_in[2*(rdgv_pkg::ROOT_W-1-rdgv_pkg::SQ_STEP*s-t) +: 2]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st_r[s]  <= st_nxt;
        val_r[s] <= val_in;
      end
    end
  end

  assign root_out = st_r[rdgv_pkg::SQ_STG-1].root;

endmodule

/* tb/tb_radial_distortion_grid_vertex_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_distortion_grid_vertex_unit
// Self-checking bench for the radial distortion grid vertex unit. Vertices go
// in with random gaps and the output stalls at random. Each vertex is also
// computed in the bench (grid placement, integer square root, Horner chain)
// and the distorted x, y and vertex index are compared in order.
// ----------------------------------------------------------------------------
module tb_radial_distortion_grid_vertex_unit;

  localparam int GX        = 32;
  localparam int GY        = 32;
  localparam int LATENCY   = 15;
  localparam int IDLE_MAX  = 60000;
  localparam int CIDX_LAST = rdgv_pkg::NCOEF - 1;

  typedef struct {
    logic signed [rdgv_pkg::XO_W-1:0]  x;
    logic signed [rdgv_pkg::CRD_W-1:0] y;
    logic [rdgv_pkg::VIDX_W-1:0]       vidx;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rdgv_pkg::IDX_W-1:0] in_col = '0;
  logic [rdgv_pkg::IDX_W-1:0] in_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [rdgv_pkg::XO_W-1:0] out_x_out;
  logic signed [rdgv_pkg::CRD_W-1:0] out_y_out;
  logic [rdgv_pkg::VIDX_W-1:0] out_vertex_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rdgv_pkg::CIDX_W-1:0] cfg_index = '0;
  logic signed [rdgv_pkg::COEF_W-1:0] cfg_data = '0;

  longint coef_q[rdgv_pkg::NCOEF];
  vertex_t pending_vertices[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit hold_output = 1'b0;
  bit randomize_stall = 1'b1;

  radial_distortion_grid_vertex_unit #(.GRID_X(GX), .GRID_Y(GY)) u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res = 0;
    longint b = 64'sd1 <<< 40;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic vertex_t distort_vertex(int col, int row);
    vertex_t v;
    longint xu, yu, r, acc, x;
    if (col > GX) col = GX;
    if (row > GY) row = GY;
    xu = (col * rdgv_pkg::ONE_Q14 + GX / 2) / GX - rdgv_pkg::ONE_Q14;
    yu = (row * rdgv_pkg::ONE_Q14 + GY / 2) / GY - rdgv_pkg::ONE_Q14;
    r = int_sqrt(xu * xu + yu * yu);
    acc = coef_q[rdgv_pkg::NCOEF-1];
    for (int k = rdgv_pkg::NCOEF - 2; k >= 0; k--)
      acc = floor_shift(acc * r + (64'sd1 <<< 13), 14) + coef_q[k];
    x = floor_shift(xu * acc + (64'sd1 <<< 19), 20);
    if (x > rdgv_pkg::X_MAX) x = rdgv_pkg::X_MAX;
    if (x < rdgv_pkg::X_MIN) x = rdgv_pkg::X_MIN;
    v.x = x[rdgv_pkg::XO_W-1:0];
    v.y = yu[rdgv_pkg::CRD_W-1:0];
    v.vidx = rdgv_pkg::VIDX_W'(row * (GX + 1) + col);
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected result", out_vertex_index, -1);
      end else begin
        vertex_t e;
        e = pending_vertices.pop_front();
        if (out_x_out !== e.x) report_mismatch("x_out", out_x_out, e.x);
        if (out_y_out !== e.y) report_mismatch("y_out", out_y_out, e.y);
        if (out_vertex_index !== e.vidx)
          report_mismatch("vertex_index", out_vertex_index, e.vidx);
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("Timeout: no request or result moved for %0d cycles", IDLE_MAX);
      $display("radial_distortion_grid_vertex_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    int wait_draw;
    wait_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    if (hold_output) begin
      out_stall <= 1'b1;
      stall_left <= 0;
    end else if (!randomize_stall) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_left <= wait_draw;
      out_stall <= (wait_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  task automatic send_vertex(int col, int row, bit gaps);
    int gap;
    gap = gaps && ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_col <= col[rdgv_pkg::IDX_W-1:0];
    in_row <= row[rdgv_pkg::IDX_W-1:0];
    do @(posedge clk); while (in_stall);
    pending_vertices.push_back(distort_vertex(col, row));
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_coef(int idx, longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[rdgv_pkg::CIDX_W-1:0];
    cfg_data <= value[rdgv_pkg::COEF_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < rdgv_pkg::NCOEF) coef_q[idx] = value;
    @(posedge clk);
  endtask

  task automatic load_coefs(longint c0, longint c1, longint c2, longint c3,
                            longint c4, longint c5, longint c6);
    longint vals[rdgv_pkg::NCOEF];
    vals = '{c0, c1, c2, c3, c4, c5, c6};
    drain_results();
    for (int k = 0; k < rdgv_pkg::NCOEF; k++) write_coef(k, vals[k]);
  endtask

  task automatic test_grid_corners();
    int pts[12][2];
    pts = '{'{0, 0}, '{32, 32}, '{0, 32}, '{32, 0}, '{16, 16}, '{1, 31},
            '{63, 63}, '{33, 5}, '{7, 40}, '{63, 0}, '{42, 21}, '{21, 42}};
    foreach (pts[i]) send_vertex(pts[i][0], pts[i][1], 1'b0);
  endtask

  task automatic test_random_vertices(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_vertex($urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
      else
        send_vertex($urandom_range(0, 32), $urandom_range(0, 32), $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic test_coef_extremes();
    load_coefs(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608);
    test_grid_corners();
    load_coefs(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    test_grid_corners();
    load_coefs(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
    test_grid_corners();
    load_coefs(0, 0, 0, 0, 0, 0, 0);
    test_grid_corners();
  endtask

  task automatic test_unknown_register();
    drain_results();
    write_coef(CIDX_LAST + 1, 8388607);
    test_grid_corners();
  endtask

  task automatic test_random_coefs(int phases, int count);
    for (int p = 0; p < phases; p++) begin
      load_coefs(int'($urandom_range(0, 16777215)) - 8388608,
                 int'($urandom_range(0, 4194303)) - 2097152,
                 int'($urandom_range(0, 16777215)) - 8388608,
                 int'($urandom_range(0, 1048575)) - 524288,
                 int'($urandom_range(0, 16777215)) - 8388608,
                 int'($urandom_range(0, 262143)) - 131072,
                 int'($urandom_range(0, 16777215)) - 8388608);
      test_random_vertices(count);
    end
  endtask

  task automatic test_backpressure();
    int hold;
    drain_results();
    hold_output = 1'b1;
    fork
      begin
        hold = 200;
        while (hold > 0) begin
          @(posedge clk);
          hold--;
        end
        hold_output = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_vertex($urandom_range(0, 32), $urandom_range(0, 32), 1'b0);
    join
    randomize_stall = 1'b0;
    test_random_vertices(100);
    randomize_stall = 1'b1;
    drain_results();
  endtask

  initial begin
    coef_q = '{1048576, 0, 0, 0, 0, 0, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_grid_corners();
    test_random_vertices(200);
    test_coef_extremes();
    test_unknown_register();
    test_random_coefs(5, 200);
    test_backpressure();
    drain_results();
    $display("Checked %0d vertices across reset, extreme and random coefficient sets,", n_checked);
    $display("including clamped indices, long output holds and back-to-back streams.");
    if (errors == 0 && pending_vertices.size() == 0)
      $display("radial_distortion_grid_vertex_unit: match");
    else
      $display("radial_distortion_grid_vertex_unit: mismatch");
    $finish;
  end

endmodule
